// ===== hw/rtl/mpef_pkg.sv =====
package mpef_pkg;

    localparam int IN_W     = 32;
    localparam int REG_W    = 31;
    localparam int RR_W     = 32;
    localparam int Q_W      = 33;
    localparam int WIDE_W   = 64;
    localparam int ARG_W    = 23;
    localparam int HP_W     = 32;
    localparam int G_W      = 30;
    localparam int K_W      = 10;
    localparam int CFG_AW   = 2;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = Q_W;
    localparam int MUL_LAT    = 2;
    localparam int EXP_LAT    = 11;
    localparam int FIFO_DEPTH = 256;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // register indexes on the configuration port
    localparam logic [CFG_AW-1:0] CFG_WELL_DEPTH       = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_WIDTH_FACTOR     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_EQUILIBRIUM_DIST = 2'd2;

    localparam logic [REG_W-1:0] Q16_ONE = 31'h0001_0000;

    localparam logic [WIDE_W-1:0] WIDE_ONE = 64'h0000_0001_0000_0000;
    localparam logic [IN_W-1:0]   POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [IN_W-1:0]   NEG_MAX  = 32'h8000_0000;
    localparam logic [ARG_W-1:0]  ARG_LIMIT = 23'h40_0000;

    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic signed [55:0] Z_BIAS    = 56'sh40_0000_0000_0000;
    localparam logic signed [K_W-1:0] K_OFFSET = 10'sd256;
    localparam logic signed [K_W-1:0] K_HUGE   = 10'sd31;

    // 2^g polynomial, Q2.30, highest term first
    localparam logic [HP_W-1:0] POW2_C5 = 32'd165394;
    localparam logic [HP_W-1:0] HORNER_C [6] = '{
        32'd1431680, 32'd10327388, 32'd59597083,
        32'd257941248, 32'd744261118, 32'h4000_0000
    };

    typedef struct packed {
        logic [WIDE_W-1:0] v;
        logic [WIDE_W-1:0] r;
    } sqrt_state_t;

    typedef struct packed {
        logic            saturated;
        logic            zero_length;
        logic [IN_W-1:0] force_z;
        logic [IN_W-1:0] force_y;
        logic [IN_W-1:0] force_x;
        logic [IN_W-1:0] energy;
    } result_t;

endpackage

// ===== hw/rtl/mpef_mulhi.sv =====
module mpef_mulhi (
    input  logic                        aclk,
    input  logic [mpef_pkg::WIDE_W-1:0] x,
    input  logic [mpef_pkg::WIDE_W-1:0] y,
    output logic [mpef_pkg::WIDE_W-1:0] p
);
    import mpef_pkg::*;

    // floor(x*y/2^32), all ones when it does not fit; partial products and result are registered
    logic [WIDE_W-1:0] ll_reg, lh_reg, hl_reg, hh_reg, p_reg;
    logic [33:0]       mid;
    logic [64:0]       hi;
    logic [WIDE_W-1:0] p_next;

    always_ff @(posedge aclk) begin
        ll_reg <= 64'(x[31:0]) * 64'(y[31:0]);
        lh_reg <= 64'(x[31:0]) * 64'(y[63:32]);
        hl_reg <= 64'(x[63:32]) * 64'(y[31:0]);
        hh_reg <= 64'(x[63:32]) * 64'(y[63:32]);
        p_reg  <= p_next;
    end

    always_comb begin
        mid = 34'(ll_reg[63:32]) + 34'(lh_reg[31:0]) + 34'(hl_reg[31:0]);
        hi  = 65'(hh_reg) + 65'(lh_reg[63:32]) + 65'(hl_reg[63:32]) + 65'(mid[33:32]);
        if (hi[64:32] != '0) begin
            p_next = '1;
        end else begin
            p_next = {hi[31:0], mid[31:0]};
        end
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/mpef_qdiv.sv =====
module mpef_qdiv (
    input  logic                      aclk,
    input  logic [mpef_pkg::RR_W-1:0] num,
    input  logic [mpef_pkg::RR_W-1:0] den,
    output logic [mpef_pkg::Q_W-1:0]  quo
);
    import mpef_pkg::*;

    // floor(num*2^32/den) for num <= den, one quotient bit per stage
    logic [Q_W-1:0]  rem_reg [DIV_STEPS-1];
    logic [RR_W-1:0] den_reg [DIV_STEPS-1];
    logic [Q_W-1:0]  quo_reg [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic [Q_W-1:0]  part;
        logic [RR_W-1:0] dd;
        logic [Q_W-1:0]  qin;
        logic            fits;

        if (s == 0) begin : g_first
            assign part = {1'b0, num};
            assign dd   = den;
            assign qin  = '0;
        end else begin : g_next
            assign part = {rem_reg[s-1][Q_W-2:0], 1'b0};
            assign dd   = den_reg[s-1];
            assign qin  = quo_reg[s-1];
        end

        assign fits = (part >= {1'b0, dd});

        always_ff @(posedge aclk) begin
            quo_reg[s] <= {qin[Q_W-2:0], fits};
        end

        if (s < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                rem_reg[s] <= fits ? (part - {1'b0, dd}) : part;
                den_reg[s] <= dd;
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

// ===== hw/rtl/morse_pair_energy_force.sv =====
// Morse pair potential engine. Each input transaction carries one pair
// displacement (x, y, z, signed Q16.16) and yields one result transaction:
// the energy D*(1-e)^2 and the force vector r*2*a*(D/rr)*(1-e)*e with
// e = exp(-a*(rr-re)), each saturated to signed Q16.16, plus a zero-length
// flag and a saturation flag. A new pair is taken every clock while s_tready
// is high; its path runs through the 32-stage square root, the 33-stage
// divider and the three chained 64-bit fractional multipliers of the
// force path. Results collect in a
// 256-entry output buffer; s_tready drops only when that many transactions
// are in flight or waiting. Write the well depth, width and equilibrium
// distance registers (unsigned Q16.16) while no transaction is in flight.
module morse_pair_energy_force (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [3*mpef_pkg::IN_W-1:0] s_tdata,    // disp_x, disp_y, disp_z
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [4*mpef_pkg::IN_W-1:0] m_tdata,    // energy, force_x, force_y, force_z
    output logic [1:0]                  m_tuser,    // zero_length, saturated
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [mpef_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [mpef_pkg::REG_W-1:0]  cfg_wdata
);
    import mpef_pkg::*;

    // pipeline timing: a value "at Tn" is the output of stage register n
    localparam int T_RR = 3 + SQRT_STEPS;          // root length
    localparam int T_U  = T_RR + EXP_LAT;          // e and |1-e|
    localparam int T_EN = T_U + 2 * MUL_LAT;       // raw energy
    localparam int T_Q  = T_RR + DIV_STEPS;        // |r_i|/rr
    localparam int T_M1 = T_Q + MUL_LAT;
    localparam int T_M2 = T_M1 + MUL_LAT;
    localparam int T_M3 = T_M2 + MUL_LAT;          // last stage, result formed here

    localparam int MAG_N  = T_M3 - 1;
    localparam int ZERO_N = T_M3 - T_RR;
    localparam int E_N    = T_M1 - T_U;
    localparam int U_N    = T_M2 - T_U;
    localparam int FLAG_N = T_M3 - T_U;
    localparam int EN_N   = T_M3 - T_EN;

    function automatic sqrt_state_t sqrt_step(input sqrt_state_t s, input int j);
        logic [WIDE_W-1:0] bit_v;
        logic [WIDE_W-1:0] trial;
        sqrt_state_t       o;
        bit_v = 64'd1 << (62 - 2 * j);
        trial = s.r + bit_v;
        if (s.v >= trial) begin
            o.v = s.v - trial;
            o.r = (s.r >> 1) + bit_v;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    function automatic logic [HP_W-1:0] horner(input logic [HP_W-1:0] c,
                                               input logic [HP_W-1:0] p,
                                               input logic [G_W-1:0]  g);
        logic [HP_W+G_W-1:0] pg;
        pg = (HP_W+G_W)'(p) * (HP_W+G_W)'(g);
        return c + pg[HP_W+G_W-1:G_W];
    endfunction

    // ---------------- configuration registers ----------------
    logic [REG_W-1:0]   depth_reg, width_reg, dist_reg;
    logic [2*REG_W-1:0] ad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            width_reg <= Q16_ONE;
            dist_reg  <= Q16_ONE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WELL_DEPTH:       depth_reg <= cfg_wdata;
                CFG_WIDTH_FACTOR:     width_reg <= cfg_wdata;
                CFG_EQUILIBRIUM_DIST: dist_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a*D is a constant between writes
    always_ff @(posedge aclk) begin
        ad_reg <= (2*REG_W)'(width_reg) * (2*REG_W)'(depth_reg);
    end

    // ---------------- flow control ----------------
    // credit count covers everything in the pipe, buffer and output register
    logic                 accept, take;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic [T_M3:1]        vld_reg;

    assign accept = s_tvalid && s_tready;
    assign take   = m_tvalid && m_tready;
    assign s_tready = (cnt_reg != (FIFO_AW+1)'(FIFO_DEPTH));

    always_comb begin
        cnt_next = cnt_reg;
        if (accept && !take) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (take && !accept) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            vld_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            vld_reg <= {vld_reg[T_M3-1:1], accept};
        end
    end

    // ---------------- magnitude, squares, square root ----------------
    logic [IN_W-1:0]   mag1_reg [3];
    logic              neg1_reg [3];
    logic [WIDE_W-1:0] sq2_reg  [3];
    sqrt_state_t       sq_reg   [SQRT_STEPS+1];
    logic [IN_W-1:0]   in_v     [3];
    logic [RR_W-1:0]   rr;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_v[i] = s_tdata[i*IN_W +: IN_W];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            neg1_reg[i] <= in_v[i][IN_W-1];
            mag1_reg[i] <= in_v[i][IN_W-1] ? (~in_v[i] + 1'b1) : in_v[i];
            sq2_reg[i]  <= WIDE_W'(mag1_reg[i]) * WIDE_W'(mag1_reg[i]);
        end
        sq_reg[0].v <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        sq_reg[0].r <= '0;
        for (int j = 0; j < SQRT_STEPS; j++) begin
            sq_reg[j+1] <= sqrt_step(sq_reg[j], j);
        end
    end

    assign rr = sq_reg[SQRT_STEPS].r[RR_W-1:0];

    // ---------------- exponential ----------------
    logic [RR_W-1:0]    tm_reg;
    logic               argpos_reg, argpos2_reg;
    logic [ARG_W-1:0]   am_reg;
    logic [63:0]        am_prod;
    logic [47:0]        am_full;
    logic signed [ARG_W:0]  argq;
    logic signed [55:0] zprod, zsum;
    logic [24:0]        zb;
    logic signed [K_W-1:0] k_next, k_reg;
    logic [G_W-1:0]     g_reg;
    logic [HP_W-1:0]    hp_reg [6];
    logic [G_W-1:0]     hg_reg [5];
    logic signed [K_W-1:0] hk_reg [6];
    logic [HP_W+1:0]    p34;
    logic signed [K_W-1:0] kneg;
    logic [WIDE_W-1:0]  e_next, e_reg, e46_reg, u_reg;
    logic               huge_next, huge_reg, huge46_reg, egt_reg;

    assign am_prod = 64'(width_reg) * 64'(tm_reg);
    assign am_full = am_prod[63:16];
    assign argq    = argpos2_reg ? $signed({1'b0, am_reg}) : -$signed({1'b0, am_reg});
    assign zprod   = 56'(argq) * 56'(LOG2E_Q30);
    assign zsum    = zprod + Z_BIAS;
    assign zb      = zsum[54:30];
    assign k_next  = $signed({1'b0, zb[24:16]}) - K_OFFSET;

    // e = 2^g * 2^k, unbounded once k reaches 31
    assign p34  = {hp_reg[5], 2'b00};
    assign kneg = -hk_reg[5];
    always_comb begin
        huge_next = 1'b0;
        e_next    = '0;
        if (hk_reg[5] >= K_HUGE) begin
            huge_next = 1'b1;
        end else if (hk_reg[5] >= 0) begin
            e_next = WIDE_W'(p34) << hk_reg[5][4:0];
        end else if (kneg < 10'sd64) begin
            e_next = WIDE_W'(p34) >> kneg[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        argpos_reg  <= (rr < RR_W'(dist_reg));
        tm_reg      <= (rr >= RR_W'(dist_reg)) ? (rr - RR_W'(dist_reg))
                                               : (RR_W'(dist_reg) - rr);
        argpos2_reg <= argpos_reg;
        am_reg      <= (am_full > 48'(ARG_LIMIT)) ? ARG_LIMIT : am_full[ARG_W-1:0];
        k_reg       <= k_next;
        g_reg       <= {zb[15:0], 14'b0};
        hp_reg[0]   <= horner(HORNER_C[0], POW2_C5, g_reg);
        hg_reg[0]   <= g_reg;
        hk_reg[0]   <= k_reg;
        for (int j = 1; j < 6; j++) begin
            hp_reg[j] <= horner(HORNER_C[j], hp_reg[j-1], hg_reg[j-1]);
            hk_reg[j] <= hk_reg[j-1];
        end
        for (int j = 1; j < 5; j++) begin
            hg_reg[j] <= hg_reg[j-1];
        end
        e_reg      <= e_next;
        huge_reg   <= huge_next;
        e46_reg    <= e_reg;
        huge46_reg <= huge_reg;
        u_reg      <= (e_reg >= WIDE_ONE) ? (e_reg - WIDE_ONE) : (WIDE_ONE - e_reg);
        egt_reg    <= (e_reg > WIDE_ONE);
    end

    // ---------------- energy ----------------
    logic [WIDE_W-1:0] uu, en_raw;

    mpef_mulhi u_uu (.aclk(aclk), .x(u_reg), .y(u_reg), .p(uu));
    mpef_mulhi u_en (.aclk(aclk), .x(WIDE_W'(depth_reg)), .y(uu), .p(en_raw));

    // ---------------- sideband delay lines ----------------
    logic [IN_W-1:0]   mag_dly  [3][MAG_N];
    logic              neg_dly  [3][MAG_N];
    logic              zero_dly [ZERO_N];
    logic [WIDE_W-1:0] e_dly    [E_N];
    logic [WIDE_W-1:0] u_dly    [U_N];
    logic              huge_dly [FLAG_N];
    logic              egt_dly  [FLAG_N];
    logic [WIDE_W-1:0] en_dly   [EN_N];

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            mag_dly[i][0] <= mag1_reg[i];
            neg_dly[i][0] <= neg1_reg[i];
            for (int k = 1; k < MAG_N; k++) begin
                mag_dly[i][k] <= mag_dly[i][k-1];
                neg_dly[i][k] <= neg_dly[i][k-1];
            end
        end
        zero_dly[0] <= (rr == '0);
        for (int k = 1; k < ZERO_N; k++) zero_dly[k] <= zero_dly[k-1];
        e_dly[0] <= e46_reg;
        for (int k = 1; k < E_N; k++) e_dly[k] <= e_dly[k-1];
        u_dly[0] <= u_reg;
        for (int k = 1; k < U_N; k++) u_dly[k] <= u_dly[k-1];
        huge_dly[0] <= huge46_reg;
        egt_dly[0]  <= egt_reg;
        for (int k = 1; k < FLAG_N; k++) begin
            huge_dly[k] <= huge_dly[k-1];
            egt_dly[k]  <= egt_dly[k-1];
        end
        en_dly[0] <= en_raw;
        for (int k = 1; k < EN_N; k++) en_dly[k] <= en_dly[k-1];
    end

    // ---------------- force lanes ----------------
    logic [WIDE_W-1:0] m3 [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        logic [Q_W-1:0]    q;
        logic [WIDE_W-1:0] m1, m2, m3_lane;

        mpef_qdiv u_div (
            .aclk (aclk),
            .num  (mag_dly[i][T_RR-2]),
            .den  (rr),
            .quo  (q)
        );
        mpef_mulhi u_m1 (.aclk(aclk), .x(WIDE_W'(ad_reg)), .y(WIDE_W'(q)), .p(m1));
        mpef_mulhi u_m2 (.aclk(aclk), .x(m1), .y(e_dly[E_N-1]), .p(m2));
        mpef_mulhi u_m3 (.aclk(aclk), .x(m2), .y(u_dly[U_N-1]), .p(m3_lane));

        assign m3[i] = m3_lane;
    end

    // ---------------- result formation ----------------
    result_t         res;
    logic [48:0]     fmag  [3];
    logic [IN_W-1:0] force_v [3];
    logic            huge_t, zero_t;

    assign huge_t = huge_dly[FLAG_N-1];
    assign zero_t = zero_dly[ZERO_N-1];

    always_comb begin
        res = '0;
        if (huge_t) begin
            res.energy    = (depth_reg != '0) ? POS_MAX : '0;
            res.saturated = (depth_reg != '0);
        end else if (en_dly[EN_N-1] > WIDE_W'(POS_MAX)) begin
            res.energy    = POS_MAX;
            res.saturated = 1'b1;
        end else begin
            res.energy = en_dly[EN_N-1][IN_W-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            fmag[i]    = m3[i][63:15];     // times two, back to Q16.16
            force_v[i] = '0;
            if (zero_t) begin
                force_v[i] = '0;
            end else if (huge_t) begin
                if (width_reg != '0 && depth_reg != '0 && mag_dly[i][MAG_N-1] != '0) begin
                    res.saturated = 1'b1;
                    force_v[i]    = neg_dly[i][MAG_N-1] ? POS_MAX : NEG_MAX;
                end
            end else if (neg_dly[i][MAG_N-1] != egt_dly[FLAG_N-1]) begin
                if (fmag[i] > 49'(NEG_MAX)) begin
                    res.saturated = 1'b1;
                    force_v[i]    = NEG_MAX;
                end else begin
                    force_v[i] = ~fmag[i][IN_W-1:0] + 1'b1;
                end
            end else if (fmag[i] > 49'(POS_MAX)) begin
                res.saturated = 1'b1;
                force_v[i]    = POS_MAX;
            end else begin
                force_v[i] = fmag[i][IN_W-1:0];
            end
        end
        res.force_x     = force_v[0];
        res.force_y     = force_v[1];
        res.force_z     = force_v[2];
        res.zero_length = zero_t;
    end

    // ---------------- output buffer ----------------
    result_t            fifo_mem [FIFO_DEPTH];
    result_t            out_reg;
    logic               out_valid_reg;
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   fcnt_reg;
    logic               wr_en, load;

    assign wr_en = vld_reg[T_M3];
    assign load  = (fcnt_reg != '0) && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fifo_mem[wr_ptr_reg] <= res;
        end
        if (load) begin
            out_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (load) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !load) begin
                fcnt_reg <= fcnt_reg + 1'b1;
            end else if (load && !wr_en) begin
                fcnt_reg <= fcnt_reg - 1'b1;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.force_z, out_reg.force_y, out_reg.force_x, out_reg.energy};
    assign m_tuser  = {out_reg.saturated, out_reg.zero_length};

endmodule
